// ----- rtl/scds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scds_pkg;

  localparam int SrcW    = 32;
  localparam int RateW   = 32;
  localparam int StW     = 2;
  localparam int PreW    = 8;
  localparam int DivW    = 8;
  localparam int PreIdxW = 7;             // prescale = 2 * index, index 1..127
  localparam int ProdW   = 48;            // widest compare product
  localparam int MpW     = 40;            // (rate + 1) * prescale
  localparam int CntW    = 3;

  localparam logic [15:0] SLOW_LIMIT = 16'(244 * 246);
  localparam logic [SrcW-1:0] SRC_RESET = 32'd1;

  typedef enum logic [StW-1:0] {
    ST_FOUND    = 2'd0,
    ST_TOO_SLOW = 2'd1,
    ST_NO_PAIR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOW,
    S_PRE,
    S_MP,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic            load;
    logic            pre_step;
    logic            mp_load;
    logic            div_step;
    logic            emit;
    logic [CntW-1:0] step_bit;
    status_t         emit_status;
  } cmd_t;

  typedef struct packed {
    logic too_slow;
    logic no_pair;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/scds_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire scds_pkg::sts_t sts,
  output scds_pkg::cmd_t     cmd
);

  scds_pkg::state_t                  state_r, state_nxt;
  logic [scds_pkg::CntW-1:0]         cnt_r, cnt_nxt;
  scds_pkg::status_t                 st_r, st_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scds_pkg::S_IDLE;
      cnt_r       <= '0;
      st_r        <= scds_pkg::ST_FOUND;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    case (state_r)
      scds_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = scds_pkg::S_SLOW;
        end
      end
      scds_pkg::S_SLOW: begin
        if (sts.too_slow) begin
          st_nxt    = scds_pkg::ST_TOO_SLOW;
          state_nxt = scds_pkg::S_EMIT;
        end else begin
          cnt_nxt   = 3'(scds_pkg::PreIdxW - 1);
          state_nxt = scds_pkg::S_PRE;
        end
      end
      scds_pkg::S_PRE: begin
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          state_nxt = scds_pkg::S_MP;
        end
      end
      scds_pkg::S_MP: begin
        if (sts.no_pair) begin
          st_nxt    = scds_pkg::ST_NO_PAIR;
          state_nxt = scds_pkg::S_EMIT;
        end else begin
          cnt_nxt   = 3'(scds_pkg::DivW - 1);
          state_nxt = scds_pkg::S_DIV;
        end
      end
      scds_pkg::S_DIV: begin
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          st_nxt    = scds_pkg::ST_FOUND;
          state_nxt = scds_pkg::S_EMIT;
        end
      end
      scds_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = scds_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = scds_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.step_bit    = cnt_r;
    cmd.emit_status = st_r;
    in_ready        = 1'b0;
    case (state_r)
      scds_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      scds_pkg::S_PRE:  cmd.pre_step = 1'b1;
      scds_pkg::S_MP:   cmd.mp_load  = !sts.no_pair;
      scds_pkg::S_DIV:  cmd.div_step = 1'b1;
      scds_pkg::S_EMIT: cmd.emit     = out_free;
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);
  end

endmodule

`default_nettype wire

// ----- rtl/scds_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scds_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [scds_pkg::SrcW-1:0]     cfg_data,
  input  wire logic [scds_pkg::RateW-1:0]    requested_rate,
  input  wire scds_pkg::cmd_t                cmd,
  output scds_pkg::sts_t                     sts,
  output logic [scds_pkg::StW-1:0]           status,
  output logic [scds_pkg::PreW-1:0]          prescale,
  output logic [scds_pkg::DivW-1:0]          serial_rate_divisor
);

  logic [scds_pkg::SrcW-1:0]    src_r;
  logic [scds_pkg::RateW-1:0]   m_r;      // clamped rate plus one
  logic [scds_pkg::PreIdxW-1:0] kf_r;     // largest failing prescale index
  logic [scds_pkg::MpW-1:0]     mp_r;
  logic [scds_pkg::DivW-1:0]    jf_r;     // largest failing divisor count
  scds_pkg::status_t            status_r;
  logic [scds_pkg::PreW-1:0]    prescale_r;
  logic [scds_pkg::DivW-1:0]    div_r;

  logic [scds_pkg::RateW-1:0]   half_src;
  logic [scds_pkg::RateW-1:0]   hz;
  logic [scds_pkg::ProdW-1:0]   src_ext;
  logic [scds_pkg::ProdW-1:0]   prod_slow;
  logic [scds_pkg::PreIdxW-1:0] k_try;
  logic [scds_pkg::ProdW-1:0]   prod_pre;
  logic                         pre_ok;
  logic [scds_pkg::PreW-1:0]    pre_val;
  logic [scds_pkg::DivW-1:0]    j_try;
  logic [scds_pkg::ProdW-1:0]   prod_div;
  logic                         div_ok;

  assign half_src  = src_r >> 1;
  assign hz        = (requested_rate > half_src) ? half_src : requested_rate;
  assign src_ext   = scds_pkg::ProdW'(src_r);

  // too slow when (hz + 1) * limit <= src, i.e. hz < src / limit
  assign prod_slow = scds_pkg::ProdW'(m_r) * scds_pkg::ProdW'(scds_pkg::SLOW_LIMIT);

  // prescale 2k with divisor 255 fits when src < (hz + 1) * 2k * 256
  assign k_try    = kf_r | (scds_pkg::PreIdxW'(1) << cmd.step_bit);
  assign prod_pre = (scds_pkg::ProdW'(m_r) * scds_pkg::ProdW'(k_try)) << 9;
  assign pre_ok   = src_ext < prod_pre;
  assign pre_val  = {scds_pkg::PreW'(kf_r) + 8'd1} << 1;

  // divisor j - 1 fits when src < (hz + 1) * prescale * j
  assign j_try    = jf_r | (scds_pkg::DivW'(1) << cmd.step_bit);
  assign prod_div = scds_pkg::ProdW'(mp_r) * scds_pkg::ProdW'(j_try);
  assign div_ok   = src_ext < prod_div;

  assign sts.too_slow = prod_slow <= src_ext;
  assign sts.no_pair  = &kf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= scds_pkg::SRC_RESET;
    end else if (cfg_we) begin
      src_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r  <= hz + 32'd1;
      kf_r <= '0;
      jf_r <= '0;
    end
    if (cmd.pre_step && !pre_ok) begin
      kf_r <= k_try;
    end
    if (cmd.mp_load) begin
      mp_r <= scds_pkg::MpW'(m_r) * scds_pkg::MpW'(pre_val);
    end
    if (cmd.div_step && !div_ok) begin
      jf_r <= j_try;
    end
    if (cmd.emit) begin
      status_r <= cmd.emit_status;
      if (cmd.emit_status == scds_pkg::ST_FOUND) begin
        prescale_r <= pre_val;
        div_r      <= jf_r;
      end else begin
        prescale_r <= '0;
        div_r      <= '0;
      end
    end
  end

  assign status              = status_r;
  assign prescale            = prescale_r;
  assign serial_rate_divisor = div_r;

endmodule

`default_nettype wire

// ----- rtl/spi_clock_divisor_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// cfg      cfg_valid/cfg_ready   cfg_source_clock (32b source clock, Hz)
// in       in_valid/in_ready     in_requested_rate (32b)
// out      out_valid/out_ready   out_status, out_prescale, out_serial_rate_divisor
//
// One transaction at a time. The prescale is found by a 7-step binary search and
// the divisor by an 8-step one, each step one multiply-compare in the datapath. A
// too-slow request skips both searches, and one with no pair skips the divisor
// search. A result waiting on out_ready does not stop the next request from being
// taken; the next result then waits in the emit state until the output is free.
// Synchronous reset sets the source clock to 1 and empties the output.

module spi_clock_divisor_search (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [scds_pkg::SrcW-1:0]    cfg_source_clock,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [scds_pkg::RateW-1:0]   in_requested_rate,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [scds_pkg::StW-1:0]          out_status,
  output logic [scds_pkg::PreW-1:0]         out_prescale,
  output logic [scds_pkg::DivW-1:0]         out_serial_rate_divisor
);

  scds_pkg::cmd_t cmd;
  scds_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  scds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scds_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid),
    .cfg_data            (cfg_source_clock),
    .requested_rate      (in_requested_rate),
    .cmd                 (cmd),
    .sts                 (sts),
    .status              (out_status),
    .prescale            (out_prescale),
    .serial_rate_divisor (out_serial_rate_divisor)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  scds_pkg::status_t st;
  logic [7:0]        prescale;
  logic [7:0]        divisor;
} divisor_pick_t;

class rate_divisor_board;
  localparam int unsigned PRE_MIN = 2;
  localparam int unsigned PRE_MAX = 254;
  localparam int unsigned DIV_MAX = 255;

  logic [31:0]   src_hz;
  divisor_pick_t pending[$];
  int            mismatches;
  int            checked;
  int            found_cnt;
  int            slow_cnt;

  function new();
    src_hz = scds_pkg::SRC_RESET;
    mismatches = 0;
    checked = 0;
    found_cnt = 0;
    slow_cnt = 0;
  endfunction

  // Quotient falls as the divisor grows, so a prescale can fit only if its
  // largest divisor does; this keeps the search short.
  function divisor_pick_t search_divisors(logic [31:0] rate);
    logic [31:0]   hz;
    logic [31:0]   prod;
    int unsigned   p;
    int unsigned   d;
    divisor_pick_t r;
    hz = rate;
    if (hz > src_hz / 2) hz = src_hz / 2;
    r.st = scds_pkg::ST_NO_PAIR;
    r.prescale = '0;
    r.divisor = '0;
    if (hz < src_hz / {16'd0, scds_pkg::SLOW_LIMIT}) begin
      r.st = scds_pkg::ST_TOO_SLOW;
      return r;
    end
    for (p = PRE_MIN; p <= PRE_MAX; p += 2) begin
      prod = p * (DIV_MAX + 1);
      if (src_hz / prod <= hz) begin
        for (d = 0; d <= DIV_MAX; d++) begin
          prod = p * (d + 1);
          if (src_hz / prod <= hz) begin
            r.st = scds_pkg::ST_FOUND;
            r.prescale = p[7:0];
            r.divisor = d[7:0];
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  function void note_request(logic [31:0] rate);
    pending.push_back(search_divisors(rate));
  endfunction

  task report_mismatch(string what);
    if (mismatches < 100) $display("%t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task check_result(logic [1:0] st, logic [7:0] pre, logic [7:0] dv);
    divisor_pick_t exp_pick;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected result status=%0d prescale=%0d divisor=%0d",
                                st, pre, dv));
      return;
    end
    exp_pick = pending.pop_front();
    checked++;
    if (exp_pick.st == scds_pkg::ST_FOUND) found_cnt++;
    if (exp_pick.st == scds_pkg::ST_TOO_SLOW) slow_cnt++;
    if (st !== exp_pick.st || pre !== exp_pick.prescale || dv !== exp_pick.divisor)
      report_mismatch($sformatf("src=%0d got status=%0d prescale=%0d divisor=%0d, want %0d/%0d/%0d",
                                src_hz, st, pre, dv, exp_pick.st, exp_pick.prescale,
                                exp_pick.divisor));
  endtask
endclass

module tb_top;
  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_source_clock;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_requested_rate;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_prescale;
  logic [7:0]  out_serial_rate_divisor;

  rate_divisor_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int sent;
  int writes;
  bit held_off;

  spi_clock_divisor_search u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_source_clock        (cfg_source_clock),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_requested_rate       (in_requested_rate),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_prescale            (out_prescale),
    .out_serial_rate_divisor (out_serial_rate_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd12 * 700000);
    $display("[spi_clock_divisor_search] ERROR");
    $finish;
  end

  task automatic send_rate(input logic [31:0] rate);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_requested_rate <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(rate);
    sent++;
  endtask

  // Drop valid and hold until every pending result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_source(input logic [31:0] hz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_source_clock <= hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.src_hz = hz;
    writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bias toward rates near the decision points for the given source clock.
  function automatic logic [31:0] pick_rate(logic [31:0] src);
    logic [31:0] base;
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom >> $urandom_range(0, 31);
      4, 5, 6: begin
        base = src / $urandom_range(2, 70000);
        return base + $urandom_range(0, 2) - 1;
      end
      7: begin
        base = src / {16'd0, scds_pkg::SLOW_LIMIT};
        return base + $urandom_range(0, 2) - 1;
      end
      8: return $urandom;
      default: begin
        p = 2 * $urandom_range(1, 127);
        base = src / (p * $urandom_range(1, 256));
        return base + $urandom_range(0, 2) - 1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_prescale, out_serial_rate_divisor);
  end

  initial begin
    out_ready = 1'b0;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && board.checked >= 300) begin
        // Starve the output long enough for the input side to back up.
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [31:0] s;
    logic [31:0] directed[$];
    int          ph;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_requested_rate = '0;
    cfg_valid = 1'b0;
    cfg_source_clock = '0;
    send_idle_pct = 22;
    recv_idle_pct = 72;
    sent = 0;
    writes = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // source clock still at its reset value
    send_rate(32'd0);
    send_rate(32'd1);
    send_rate(32'hFFFF_FFFF);
    drain_results();

    s = 32'd100_000_000;
    write_source(s);
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                 s / 2, s / 2 - 1, s / 60024, s / 60024 - 1, s / 60024 + 1,
                 s / 512, s / 512 - 1, s / (254 * 256), s / 3, s / 5, s / 7, s / 1000};
    foreach (directed[i]) send_rate(directed[i]);
    drain_results();

    // zero source clock: first candidate always fits
    write_source(32'd0);
    send_rate(32'd0);
    send_rate(32'hFFFF_FFFF);
    drain_results();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: s = 32'hFFFF_FFFF;
        1: s = 32'd100_000_000;
        2: s = 32'd2;
        3: s = {16'd0, scds_pkg::SLOW_LIMIT};
        4: s = 32'd48_000_000;
        5: s = $urandom;
        6: s = $urandom >> $urandom_range(8, 24);
        7: s = 32'd0;
        8: s = $urandom;
        default: s = 32'd1;
      endcase
      if (ph == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 22;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_source(s);
      repeat (150) send_rate(pick_rate(s));
      drain_results();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d rate requests across %0d source clock writes:", sent, writes);
    $display("  %0d divisor pairs found, %0d rejected as too slow", board.found_cnt,
             board.slow_cnt);
    if (board.mismatches == 0)
      $display("[spi_clock_divisor_search] OK");
    else
      $display("[spi_clock_divisor_search] ERROR");
    $finish;
  end
endmodule
